// File: rtl/i2cbm_pkg.sv
// Package for the bit-level I2C master: transfer payload types, mode codes
// and the one-hot command state encoding.
// No dependencies.
package i2cbm_pkg;

    localparam int DELAY_W = 10;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    // Codes carried in the mode field of an input transfer.
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_SACK  = 3'd5;
    localparam logic [2:0] MODE_RACK  = 3'd6;
    localparam logic [2:0] MODE_NOP   = 3'd7;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_STOP  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_SACK  = 7'b0100000,
        ST_RACK  = 7'b1000000
    } cmd_state_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [BYTE_W-1:0] data_byte;
        logic              ack_value;
        logic              sda_sample;
    } in_item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_released;
        logic              busy_res;
        logic              done_res;
        logic              rejected;
        logic [BYTE_W-1:0] read_data;
        logic              ack_seen;
    } out_item_t;

endpackage

// File: rtl/i2cbm_seq.sv
// Command sequencer of the bit-level I2C master: holds the pin, phase and
// byte state and computes the result of each accepted transfer.
// Depends on i2cbm_pkg.
module i2cbm_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [i2cbm_pkg::DELAY_W-1:0]    cfg_wdata,
    input  logic                             item_accept,
    input  i2cbm_pkg::in_item_t              item_in,
    output i2cbm_pkg::out_item_t             result
);
    import i2cbm_pkg::*;

    logic [DELAY_W-1:0] delay_ticks_reg;
    cmd_state_t         cmd_reg, cmd_next;
    logic [1:0]         phase_reg, phase_next;
    logic [2:0]         bit_reg, bit_next;
    logic [DELAY_W-1:0] tick_reg, tick_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  read_byte_reg, read_byte_next;
    logic               ack_reg, ack_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               release_reg, release_next;

    logic               step;
    logic               fin;
    logic               apply;
    logic               done;
    logic               rej;
    logic [DELAY_W-1:0] limit;

    function automatic cmd_state_t mode_to_state(input logic [2:0] mode);
        cmd_state_t st;
        unique case (mode)
            MODE_START: st = ST_START;
            MODE_STOP:  st = ST_STOP;
            MODE_WRITE: st = ST_WRITE;
            MODE_READ:  st = ST_READ;
            MODE_SACK:  st = ST_SACK;
            MODE_RACK:  st = ST_RACK;
            default:    st = ST_IDLE;
        endcase
        return st;
    endfunction

    always_comb begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        tick_next      = tick_reg;
        shift_next     = shift_reg;
        read_byte_next = read_byte_reg;
        ack_next       = ack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        release_next   = release_reg;
        step           = 1'b0;
        fin            = 1'b0;
        apply          = 1'b0;
        done           = 1'b0;
        rej            = 1'b0;
        // A programmed delay of zero behaves as a single tick.
        limit = (delay_ticks_reg == '0) ? DELAY_W'(1) : delay_ticks_reg;

        if (item_accept) begin
            if (item_in.mode == MODE_TICK) begin
                if (cmd_reg != ST_IDLE) begin
                    tick_next = tick_reg + DELAY_W'(1);
                    step      = (tick_next >= limit);
                end
            end else if (item_in.mode != MODE_NOP) begin
                if (cmd_reg != ST_IDLE) begin
                    rej = 1'b1;
                end else begin
                    cmd_next   = mode_to_state(item_in.mode);
                    phase_next = '0;
                    bit_next   = '0;
                    tick_next  = '0;
                    if (item_in.mode == MODE_WRITE) begin
                        shift_next = item_in.data_byte;
                    end else if (item_in.mode == MODE_SACK) begin
                        shift_next = {item_in.ack_value, 7'b0};
                    end else if (item_in.mode == MODE_READ) begin
                        shift_next = '0;
                    end
                    apply = 1'b1;
                end
            end
        end

        if (step) begin
            // The sample phase takes SDA from the tick that ends its delay.
            if (cmd_reg == ST_READ && phase_reg == 2'd2 && item_in.sda_sample) begin
                shift_next = shift_reg | (MSB_MASK >> bit_reg);
            end
            if (cmd_reg == ST_RACK && phase_reg == 2'd2) begin
                ack_next = item_in.sda_sample;
            end
            unique case (cmd_reg)
                ST_START, ST_RACK: begin
                    if (phase_reg == 2'd3) fin = 1'b1;
                    else phase_next = phase_reg + 2'd1;
                end
                ST_STOP, ST_SACK: begin
                    if (phase_reg >= 2'd2) fin = 1'b1;
                    else phase_next = phase_reg + 2'd1;
                end
                ST_WRITE: begin
                    if (phase_reg < 2'd2) begin
                        phase_next = phase_reg + 2'd1;
                    end else if (bit_reg != 3'd7) begin
                        bit_next   = bit_reg + 3'd1;
                        shift_next = shift_reg << 1;
                        phase_next = '0;
                    end else begin
                        fin = 1'b1;
                    end
                end
                ST_READ: begin
                    if (phase_reg != 2'd3) begin
                        phase_next = phase_reg + 2'd1;
                    end else if (bit_reg != 3'd7) begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = 2'd1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                default: fin = 1'b1;
            endcase
            tick_next = '0;
            if (fin) begin
                if (cmd_reg == ST_READ) read_byte_next = shift_next;
                if (cmd_reg == ST_READ || cmd_reg == ST_RACK) release_next = 1'b0;
                cmd_next   = ST_IDLE;
                phase_next = '0;
                bit_next   = '0;
                done       = 1'b1;
            end else begin
                apply = 1'b1;
            end
        end

        // Pin changes made at the start of the phase just entered.
        if (apply) begin
            unique case (cmd_next)
                ST_START: begin
                    if (phase_next == 2'd0) sda_next = 1'b1;
                    else if (phase_next == 2'd1) scl_next = 1'b1;
                    else if (phase_next == 2'd2) sda_next = 1'b0;
                    else scl_next = 1'b0;
                end
                ST_STOP: begin
                    if (phase_next == 2'd0) sda_next = 1'b0;
                    else if (phase_next == 2'd1) scl_next = 1'b1;
                    else sda_next = 1'b1;
                end
                ST_WRITE, ST_SACK: begin
                    if (phase_next == 2'd0) sda_next = shift_next[BYTE_W-1];
                    else if (phase_next == 2'd1) scl_next = 1'b1;
                    else scl_next = 1'b0;
                end
                ST_READ: begin
                    if (phase_next == 2'd0) begin
                        sda_next = 1'b1;
                    end else if (phase_next == 2'd1) begin
                        scl_next     = 1'b1;
                        release_next = 1'b1;
                    end else if (phase_next == 2'd3) begin
                        scl_next = 1'b0;
                    end
                end
                ST_RACK: begin
                    if (phase_next == 2'd0) sda_next = 1'b1;
                    else if (phase_next == 2'd1) scl_next = 1'b1;
                    else if (phase_next == 2'd2) release_next = 1'b1;
                    else scl_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_W'(1);
            cmd_reg         <= ST_IDLE;
            phase_reg       <= '0;
            bit_reg         <= '0;
            tick_reg        <= '0;
            shift_reg       <= '0;
            read_byte_reg   <= '0;
            ack_reg         <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            release_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                delay_ticks_reg <= cfg_wdata;
            end
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            read_byte_reg <= read_byte_next;
            ack_reg       <= ack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            release_reg   <= release_next;
        end
    end

    always_comb begin
        result.scl_level    = scl_next;
        result.sda_level    = sda_next;
        result.sda_released = release_next;
        result.busy_res     = (cmd_next != ST_IDLE);
        result.done_res     = done;
        result.rejected     = rej;
        result.read_data    = read_byte_next;
        result.ack_seen     = ack_next;
    end

endmodule

// File: rtl/i2cbm_obuf.sv
// Result register of the bit-level I2C master: holds one result transfer
// until the downstream side takes it.
// Depends on i2cbm_pkg.
module i2cbm_obuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2cbm_pkg::out_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cbm_pkg::out_item_t  out_data
);
    import i2cbm_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    // A new result may enter when the register is empty or is drained now.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/i2c_bit_level_master.sv
// Bit-level I2C master: an accepted input transfer has its result in the output
// register in the cycle after; throughput is one transfer per cycle while the
// register is empty or drained by m_ready, fed by the combinational sequencer.
// Synchronous active-low reset sets SCL and SDA high, SDA driven, the block
// idle, the delay to one tick and leaves no result pending.
// Depends on i2cbm_pkg, i2cbm_seq and i2cbm_obuf.
module i2c_bit_level_master (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [i2cbm_pkg::DELAY_W-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  i2cbm_pkg::in_item_t            s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output i2cbm_pkg::out_item_t           m_data
);
    import i2cbm_pkg::*;

    logic      accept;
    out_item_t result;

    assign accept = s_valid && s_ready;

    i2cbm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_accept (accept),
        .item_in     (s_data),
        .result      (result)
    );

    i2cbm_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // A completing transfer always leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res))
        else $error("done reported while still busy");

    // A command is only rejected while another one is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.rejected) |-> m_data.busy_res)
        else $error("rejection reported while idle");

    // SDA is released only inside a read or receive-ack sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sda_released) |-> m_data.busy_res)
        else $error("SDA left released after the command ended");

    // Every accepted input transfer produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transfer produced no result");

endmodule
